### sv/jldp_pkg.sv
// ----------------------------------------------------------------------------
// jldp_pkg
// Shared widths, constants, codes and helpers of the jerk-limited
// deceleration profile block.
// ----------------------------------------------------------------------------
`default_nettype none

package jldp_pkg;

    // Field widths
    localparam int POS_W   = 32;
    localparam int SPD_W   = 23;
    localparam int ACC_W   = 22;
    localparam int TIME_W  = 32;
    localparam int JERK_W  = 23;
    localparam int RATIO_W = 17;

    // Shared multiplier operand width (signed)
    localparam int MUL_W = 34;

    // Shared divider widths
    localparam int DIV_NW = 52;
    localparam int DIV_DW = 24;

    // Square root input width
    localparam int SQRT_W = 64;

    // Configuration port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Fixed-point constants
    localparam logic [RATIO_W-1:0] RATIO_ONE    = 17'd65536;
    localparam logic [SPD_W-1:0]   SPEED_EPS    = 23'd656;
    localparam logic [TIME_W-1:0]  DT_DEFAULT   = 32'd6554;
    localparam logic [TIME_W-1:0]  STEP_DEFAULT = 32'd100000;
    localparam logic [SPD_W-1:0]   SPEED_MAX    = 23'h7FFFFF;
    localparam logic [19:0]        US_PER_SEC   = 20'd1000000;

    // Register reset values
    localparam logic [ACC_W-1:0]   MIN_ACCEL_RST   = 22'h3868F6; // -497418
    localparam logic [JERK_W-1:0]  MIN_JERK_RST    = 23'h73599A; // -829030
    localparam logic [RATIO_W-1:0] DECEL_RATIO_RST = 17'd39322;
    localparam logic [RATIO_W-1:0] JERK_RATIO_RST  = 17'd39322;
    localparam logic [RATIO_W-1:0] SPEED_RATIO_RST = 17'd0;

    // Register map
    typedef enum logic [2:0] {
        REG_MIN_ACCEL   = 3'd0,
        REG_MIN_JERK    = 3'd1,
        REG_DECEL_RATIO = 3'd2,
        REG_JERK_RATIO  = 3'd3,
        REG_SPEED_RATIO = 3'd4
    } t_reg_idx;

    // Where the sequencer goes after a point has been emitted
    typedef enum logic [1:0] {
        AFT_START,
        AFT_NEXT,
        AFT_LAST
    } t_after;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_DIST_X,
        S_DIST_Y,
        S_SQRT,
        S_SQRT_WAIT,
        S_EMIT,
        S_DT,
        S_DT_WAIT,
        S_TD,
        S_JERK,
        S_PHASE,
        S_AA,
        S_MAG,
        S_MAG_WAIT,
        S_JD,
        S_NA,
        S_AVG,
        S_AVG_LO,
        S_AVG_HI,
        S_NV,
        S_TIME,
        S_GAP,
        S_STEP,
        S_STEP_WAIT,
        S_TSUM,
        S_UPD,
        S_OUT,
        S_GOAL,
        S_HOLD
    } t_state;

    // Start/done pair of an iterative unit
    typedef struct packed {
        logic start;
    } t_unit_req;

    typedef struct packed {
        logic done;
    } t_unit_rsp;

    // Ratios above one act as one
    function automatic logic [RATIO_W-1:0] ratio_clip(input logic [RATIO_W-1:0] r);
        return (r > RATIO_ONE) ? RATIO_ONE : r;
    endfunction

endpackage

`default_nettype wire

### sv/jldp_if.sv
// ----------------------------------------------------------------------------
// jldp_if
// Valid/ready channels for trajectory points in and revised points out.
// ----------------------------------------------------------------------------
`default_nettype none

interface jldp_pt_in_if;
    import jldp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [SPD_W-1:0]         speed_in;
    logic signed [ACC_W-1:0]  accel_in;
    logic [TIME_W-1:0]        time_in;
    logic                     start_point;
    logic                     last_point;

    modport source (
        output valid, pos_x, pos_y, speed_in, accel_in, time_in, start_point, last_point,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, speed_in, accel_in, time_in, start_point, last_point,
        output ready
    );
endinterface

interface jldp_pt_out_if;
    import jldp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [SPD_W-1:0]         speed_out;
    logic signed [ACC_W-1:0]  accel_out;
    logic [TIME_W-1:0]        time_out;
    logic                     run_end;

    modport source (
        output valid, speed_out, accel_out, time_out, run_end,
        input  ready
    );
    modport sink (
        input  valid, speed_out, accel_out, time_out, run_end,
        output ready
    );
endinterface

`default_nettype wire

### sv/jldp_div.sv
// ----------------------------------------------------------------------------
// jldp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jldp_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire jldp_pkg::t_unit_req            i_req,
    input  wire logic [jldp_pkg::DIV_NW-1:0]    i_num,
    input  wire logic [jldp_pkg::DIV_DW-1:0]    i_den,
    output jldp_pkg::t_unit_rsp                 o_rsp,
    output logic [jldp_pkg::DIV_NW-1:0]         o_quo
);
    import jldp_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_NW-1:0] r_num;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW:0]   trial;
    logic              fits;

    // next partial remainder with the next dividend bit brought down
    assign trial = {r_rem, r_num[DIV_NW-1]};
    assign fits  = (trial >= {1'b0, r_den});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits shift in where dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= DIV_DW'(trial - {1'b0, r_den});
            end else begin
                r_rem <= trial[DIV_DW-1:0];
            end
            r_num <= {r_num[DIV_NW-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_quo      = r_num;

endmodule

`default_nettype wire

### sv/jldp_isqrt.sv
// ----------------------------------------------------------------------------
// jldp_isqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jldp_isqrt (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire jldp_pkg::t_unit_req            i_req,
    input  wire logic [jldp_pkg::SQRT_W-1:0]    i_val,
    output jldp_pkg::t_unit_rsp                 o_rsp,
    output logic [jldp_pkg::SQRT_W/2-1:0]       o_root
);
    import jldp_pkg::*;

    localparam int RW    = SQRT_W / 2;
    localparam int CNT_W = $clog2(RW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SQRT_W-1:0] r_val;
    logic [RW+1:0]    r_rem;
    logic [RW-1:0]    r_root;
    logic [RW+3:0]    rem4;
    logic [RW+3:0]    trial;
    logic             fits;

    // bring down two bits, try root*4+1
    assign rem4  = {r_rem, r_val[SQRT_W-1:SQRT_W-2]};
    assign trial = {2'b00, r_root, 2'b01};
    assign fits  = (rem4 >= trial);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(RW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_val  <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[SQRT_W-3:0], 2'b00};
            if (fits) begin
                r_rem  <= (RW+2)'(rem4 - trial);
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= rem4[RW+1:0];
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_root     = r_root;

endmodule

`default_nettype wire

### sv/jerk_limited_decel_profile_top.sv
// ----------------------------------------------------------------------------
// jerk_limited_decel_profile_top
// S-curve deceleration reviser: rewrites speed (Q7.16), acceleration (signed
// Q6.16) and time (microseconds) of trajectory points, one point emitted one transfer late.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake      | payload
//  i_pt     | in  | valid/ready    | pos_x pos_y speed_in accel_in time_in start_point last_point
//  o_pt     | out | valid/ready    | speed_out accel_out time_out run_end
//  apb      | in  | psel/penable   | paddr pwdata -> prdata, pready tied high
//
//  A distance between points takes two multiplies and a 32-step square
//  root, and each revised point emitted may run the shared divider up to
//  three times (step time, jerk-out test, time step). At most two points
//  are emitted per transfer.
//  Reset is synchronous; no clearing pass. The block takes no input while a
//  point is in work; a full output register holds the sequencer until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module jerk_limited_decel_profile_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    jldp_pt_in_if.sink                          i_pt,
    jldp_pt_out_if.source                       o_pt,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [jldp_pkg::APB_AW-1:0]    paddr,
    input  wire logic [jldp_pkg::APB_DW-1:0]    pwdata,
    output logic [jldp_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);
    import jldp_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [ACC_W-1:0]   r_min_accel;
    logic [JERK_W-1:0]  r_min_jerk;
    logic [RATIO_W-1:0] r_decel_ratio;
    logic [RATIO_W-1:0] r_jerk_ratio;
    logic [RATIO_W-1:0] r_speed_ratio;
    t_reg_idx           reg_idx;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_accel   <= MIN_ACCEL_RST;
            r_min_jerk    <= MIN_JERK_RST;
            r_decel_ratio <= DECEL_RATIO_RST;
            r_jerk_ratio  <= JERK_RATIO_RST;
            r_speed_ratio <= SPEED_RATIO_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_MIN_ACCEL:   r_min_accel   <= pwdata[ACC_W-1:0];
                REG_MIN_JERK:    r_min_jerk    <= pwdata[JERK_W-1:0];
                REG_DECEL_RATIO: r_decel_ratio <= pwdata[RATIO_W-1:0];
                REG_JERK_RATIO:  r_jerk_ratio  <= pwdata[RATIO_W-1:0];
                REG_SPEED_RATIO: r_speed_ratio <= pwdata[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    // read back, signed registers sign-extended
    always_comb begin
        unique case (reg_idx)
            REG_MIN_ACCEL:   prdata = {{(APB_DW-ACC_W){r_min_accel[ACC_W-1]}}, r_min_accel};
            REG_MIN_JERK:    prdata = {{(APB_DW-JERK_W){r_min_jerk[JERK_W-1]}}, r_min_jerk};
            REG_DECEL_RATIO: prdata = {{(APB_DW-RATIO_W){1'b0}}, r_decel_ratio};
            REG_JERK_RATIO:  prdata = {{(APB_DW-RATIO_W){1'b0}}, r_jerk_ratio};
            REG_SPEED_RATIO: prdata = {{(APB_DW-RATIO_W){1'b0}}, r_speed_ratio};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    t_state r_state, n_state;
    t_after r_after;

    // accepted input
    logic signed [POS_W-1:0] r_in_x, r_in_y;
    logic [SPD_W-1:0]        r_in_spd;
    logic signed [ACC_W-1:0] r_in_acc;
    logic [TIME_W-1:0]       r_in_time;
    logic                    r_in_start, r_in_last;

    // held point
    logic signed [POS_W-1:0] r_held_x, r_held_y;
    logic [SPD_W-1:0]        r_held_spd;
    logic signed [ACC_W-1:0] r_held_acc;
    logic [TIME_W-1:0]       r_held_time;
    logic                    r_held_valid, r_held_first;

    // run state
    logic [SPD_W-1:0]        r_run_spd, r_goal, r_prev_spd;
    logic signed [ACC_W-1:0] r_run_acc;
    logic                    r_bypass;
    logic [TIME_W-1:0]       r_prev_gap, r_elapsed;

    // work registers of one emitted point
    logic [POS_W-1:0]        r_ux, r_uy;
    logic [2*POS_W:0]        r_sq;
    logic [POS_W-1:0]        r_d;
    logic                    r_has_next, r_end;
    logic [TIME_W-1:0]       r_dt;
    logic signed [ACC_W-1:0] r_td;
    logic signed [JERK_W-1:0] r_j;
    logic                    r_out_phase;
    logic [DIV_NW-1:0]       r_prod;
    logic signed [39:0]      r_jd;
    logic signed [41:0]      r_na;
    logic signed [41:0]      r_avg;
    logic [31:0]             r_lo;
    logic signed [57:0]      r_hi;
    logic [SPD_W-1:0]        r_sp, r_avg2;
    logic signed [ACC_W-1:0] r_ac;
    logic [TIME_W-1:0]       r_t;
    logic [TIME_W:0]         r_step;

    // output register
    logic                    r_o_valid;
    logic [SPD_W-1:0]        r_o_spd;
    logic signed [ACC_W-1:0] r_o_acc;
    logic [TIME_W-1:0]       r_o_time;
    logic                    r_o_end;

    // ------------------------------------------------------------------
    // shared units
    // ------------------------------------------------------------------
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    t_unit_req                 div_req, sqrt_req;
    t_unit_rsp                 div_rsp, sqrt_rsp;
    logic [DIV_NW-1:0]         div_num, div_quo;
    logic [DIV_DW-1:0]         div_den;
    logic [POS_W-1:0]          sqrt_root;

    assign mul_p = mul_a * mul_b;

    jldp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_rsp   (div_rsp),
        .o_quo   (div_quo)
    );

    jldp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sqrt_req),
        .i_val   (r_sq[2*POS_W-1:0]),
        .o_rsp   (sqrt_rsp),
        .o_root  (sqrt_root)
    );

    // ------------------------------------------------------------------
    // combinational helpers
    // ------------------------------------------------------------------
    logic                    in_fire, out_free, out_load, in_ready;
    logic                    dt_div;
    logic signed [POS_W:0]   dx, dy;
    logic [JERK_W-1:0]       j_abs;
    logic [SPD_W-1:0]        goal_raw;
    logic signed [44:0]      v_end;
    logic signed [41:0]      a_w, jd_w, td_w, na_calc, t_calc;
    logic signed [42:0]      acc_sum;
    logic signed [59:0]      nv;
    logic [SPD_W:0]          spd_sum;
    logic [TIME_W:0]         t_sum;
    logic [ACC_W-1:0]        na_sat;

    assign in_fire  = i_pt.valid && in_ready;
    assign out_free = !r_o_valid || o_pt.ready;
    assign dt_div   = r_has_next && (r_run_spd >= SPEED_EPS);

    assign dx    = $signed({r_in_x[POS_W-1], r_in_x}) - $signed({r_held_x[POS_W-1], r_held_x});
    assign dy    = $signed({r_in_y[POS_W-1], r_in_y}) - $signed({r_held_y[POS_W-1], r_held_y});
    assign j_abs = r_j[JERK_W-1] ? JERK_W'(-r_j) : r_j;

    assign goal_raw = mul_p[38:16];

    // jerk-out test: speed after ramping acceleration to zero
    assign v_end = $signed({22'b0, r_run_spd})
                   + (r_run_acc[ACC_W-1] ? -$signed({3'b0, div_quo[41:0]})
                                         :  $signed({3'b0, div_quo[41:0]}));

    // new acceleration per phase
    assign a_w  = 42'(r_run_acc);
    assign jd_w = 42'(r_jd);
    assign td_w = 42'(r_td);
    always_comb begin
        t_calc = '0;
        if (r_out_phase) begin
            t_calc  = a_w - jd_w;
            na_calc = (t_calc > 0) ? '0 : t_calc;
        end else if (a_w > td_w) begin
            t_calc  = a_w + jd_w;
            na_calc = (t_calc < td_w) ? td_w : t_calc;
        end else begin
            na_calc = td_w;
        end
    end

    assign acc_sum = 43'(a_w) + 43'(r_na);

    // trapezoid: v + floor(avg*dt / 2^16), avg split at bit 16
    assign nv = 60'(r_hi) + $signed({28'b0, r_lo}) + $signed({37'b0, r_run_spd});

    always_comb begin
        if (r_na > $signed(42'sd2097151)) begin
            na_sat = ACC_W'(22'h1FFFFF);
        end else if (r_na < $signed(-42'sd2097152)) begin
            na_sat = ACC_W'(22'h200000);
        end else begin
            na_sat = r_na[ACC_W-1:0];
        end
    end

    assign spd_sum = {1'b0, r_prev_spd} + {1'b0, r_sp};
    assign t_sum   = {1'b0, r_elapsed} + r_step;

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (in_fire) n_state = S_DISPATCH;
            S_DISPATCH: begin
                if (r_in_start) begin
                    n_state = r_held_valid ? S_EMIT : S_GOAL;
                end else begin
                    n_state = r_held_valid ? S_DIST_X : S_IDLE;
                end
            end
            S_DIST_X:    n_state = S_DIST_Y;
            S_DIST_Y:    n_state = S_SQRT;
            S_SQRT:      n_state = r_sq[2*POS_W] ? S_EMIT : S_SQRT_WAIT;
            S_SQRT_WAIT: if (sqrt_rsp.done) n_state = S_EMIT;
            S_EMIT: begin
                if (r_bypass) begin
                    n_state = S_OUT;
                end else if (r_run_spd <= r_goal) begin
                    n_state = S_TIME;
                end else begin
                    n_state = S_DT;
                end
            end
            S_DT:        n_state = dt_div ? S_DT_WAIT : S_TD;
            S_DT_WAIT:   if (div_rsp.done) n_state = S_TD;
            S_TD:        n_state = S_JERK;
            S_JERK:      n_state = S_PHASE;
            S_PHASE:     n_state = (r_j == '0) ? S_JD : S_AA;
            S_AA:        n_state = S_MAG;
            S_MAG:       n_state = S_MAG_WAIT;
            S_MAG_WAIT:  if (div_rsp.done) n_state = S_JD;
            S_JD:        n_state = S_NA;
            S_NA:        n_state = S_AVG;
            S_AVG:       n_state = S_AVG_LO;
            S_AVG_LO:    n_state = S_AVG_HI;
            S_AVG_HI:    n_state = S_NV;
            S_NV:        n_state = S_TIME;
            S_TIME: begin
                if (r_held_first) begin
                    n_state = S_UPD;
                end else if (spd_sum[SPD_W:1] >= SPEED_EPS) begin
                    n_state = S_GAP;
                end else begin
                    n_state = S_TSUM;
                end
            end
            S_GAP:       n_state = S_STEP;
            S_STEP:      n_state = S_STEP_WAIT;
            S_STEP_WAIT: if (div_rsp.done) n_state = S_TSUM;
            S_TSUM:      n_state = S_UPD;
            S_UPD:       n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    unique case (r_after)
                        AFT_START: n_state = S_GOAL;
                        AFT_NEXT:  n_state = S_HOLD;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_GOAL:      n_state = S_HOLD;
            S_HOLD:      n_state = r_in_last ? S_EMIT : S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: unit controls and multiplier operands
    // ------------------------------------------------------------------
    always_comb begin
        in_ready       = 1'b0;
        out_load       = 1'b0;
        div_req.start  = 1'b0;
        sqrt_req.start = 1'b0;
        div_num        = r_prod;
        div_den        = {1'b0, r_avg2};
        mul_a          = '0;
        mul_b          = '0;
        unique case (r_state)
            S_IDLE:   in_ready = 1'b1;
            S_DIST_X: begin
                mul_a = $signed({2'b0, r_ux});
                mul_b = $signed({2'b0, r_ux});
            end
            S_DIST_Y: begin
                mul_a = $signed({2'b0, r_uy});
                mul_b = $signed({2'b0, r_uy});
            end
            S_SQRT:   sqrt_req.start = !r_sq[2*POS_W];
            S_DT: begin
                div_req.start = dt_div;
                div_num       = {4'b0, r_d, 16'b0};
                div_den       = {1'b0, r_run_spd};
            end
            S_TD: begin
                mul_a = MUL_W'($signed(r_min_accel));
                mul_b = $signed({17'b0, ratio_clip(r_decel_ratio)});
            end
            S_JERK: begin
                mul_a = MUL_W'($signed(r_min_jerk));
                mul_b = $signed({17'b0, ratio_clip(r_jerk_ratio)});
            end
            S_AA: begin
                mul_a = MUL_W'(r_run_acc);
                mul_b = MUL_W'(r_run_acc);
            end
            S_MAG: begin
                div_req.start = 1'b1;
                div_den       = {j_abs, 1'b0};
            end
            S_JD: begin
                mul_a = MUL_W'(r_j);
                mul_b = $signed({2'b0, r_dt});
            end
            S_AVG_LO: begin
                mul_a = $signed({18'b0, r_avg[15:0]});
                mul_b = $signed({2'b0, r_dt});
            end
            S_AVG_HI: begin
                mul_a = MUL_W'($signed(r_avg[41:16]));
                mul_b = $signed({2'b0, r_dt});
            end
            S_GAP: begin
                mul_a = $signed({2'b0, r_prev_gap});
                mul_b = $signed({14'b0, US_PER_SEC});
            end
            S_STEP:   div_req.start = 1'b1;
            S_OUT:    out_load = out_free;
            S_GOAL: begin
                mul_a = $signed({11'b0, r_in_spd});
                mul_b = $signed({17'b0, ratio_clip(r_speed_ratio)});
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_held_valid <= 1'b0;
            r_held_first <= 1'b0;
            r_bypass     <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_o_valid    <= 1'b1;
                r_held_first <= 1'b0;
                if (r_after == AFT_LAST) r_held_valid <= 1'b0;
            end else if (o_pt.ready) begin
                r_o_valid <= 1'b0;
            end
            if (r_state == S_GOAL) begin
                r_held_first <= 1'b1;
                r_bypass     <= (r_in_spd <= ((goal_raw < SPEED_EPS) ? '0 : goal_raw));
            end
            if (r_state == S_HOLD) r_held_valid <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_in_x     <= i_pt.pos_x;
                    r_in_y     <= i_pt.pos_y;
                    r_in_spd   <= i_pt.speed_in;
                    r_in_acc   <= i_pt.accel_in;
                    r_in_time  <= i_pt.time_in;
                    r_in_start <= i_pt.start_point;
                    r_in_last  <= i_pt.last_point;
                end
            end
            S_DISPATCH: begin
                // old run closes with the default step
                r_has_next <= 1'b0;
                r_d        <= '0;
                r_end      <= 1'b1;
                r_after    <= AFT_START;
                r_ux       <= dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
                r_uy       <= dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
            end
            S_DIST_X: r_sq <= {1'b0, mul_p[2*POS_W-1:0]};
            S_DIST_Y: r_sq <= r_sq + {1'b0, mul_p[2*POS_W-1:0]};
            S_SQRT: begin
                r_has_next <= 1'b1;
                r_end      <= 1'b0;
                r_after    <= AFT_NEXT;
                r_d        <= '1;
            end
            S_SQRT_WAIT: if (sqrt_rsp.done) r_d <= sqrt_root;
            S_EMIT: begin
                if (r_bypass) begin
                    r_sp <= r_held_spd;
                    r_ac <= r_held_acc;
                    r_t  <= r_held_time;
                end else if (r_run_spd <= r_goal) begin
                    // target reached: hold at target
                    r_sp <= r_goal;
                    r_ac <= '0;
                end
            end
            S_DT:      if (!dt_div) r_dt <= DT_DEFAULT;
            S_DT_WAIT: begin
                if (div_rsp.done) begin
                    r_dt <= (div_quo[DIV_NW-1:TIME_W] != '0) ? '1 : div_quo[TIME_W-1:0];
                end
            end
            S_TD:      r_td <= mul_p[37:16];
            S_JERK:    r_j  <= mul_p[38:16];
            S_PHASE:   r_out_phase <= r_run_acc[ACC_W-1];
            S_AA:      r_prod <= mul_p[DIV_NW-1:0];
            S_MAG_WAIT: if (div_rsp.done) r_out_phase <= (v_end <= $signed({22'b0, r_goal}));
            S_JD:      r_jd  <= mul_p[55:16];
            S_NA:      r_na  <= na_calc;
            S_AVG:     r_avg <= acc_sum[42:1];
            S_AVG_LO:  r_lo  <= mul_p[47:16];
            S_AVG_HI:  r_hi  <= mul_p[57:0];
            S_NV: begin
                // clamp to [goal, max]; clamped up means no acceleration
                if (nv < $signed({37'b0, r_goal})) begin
                    r_sp      <= r_goal;
                    r_ac      <= '0;
                    r_run_spd <= r_goal;
                    r_run_acc <= '0;
                end else begin
                    r_sp      <= (nv > $signed({37'b0, SPEED_MAX})) ? SPEED_MAX : nv[SPD_W-1:0];
                    r_ac      <= na_sat;
                    r_run_spd <= (nv > $signed({37'b0, SPEED_MAX})) ? SPEED_MAX : nv[SPD_W-1:0];
                    r_run_acc <= na_sat;
                end
            end
            S_TIME: begin
                r_avg2 <= spd_sum[SPD_W:1];
                r_step <= {1'b0, STEP_DEFAULT};
                if (r_held_first) r_t <= '0;
            end
            S_GAP:     r_prod <= mul_p[DIV_NW-1:0];
            S_STEP_WAIT: begin
                if (div_rsp.done) begin
                    r_step <= (div_quo[DIV_NW-1:TIME_W] != '0) ? {1'b1, {TIME_W{1'b0}}}
                                                               : {1'b0, div_quo[TIME_W-1:0]};
                end
            end
            S_TSUM:    r_t <= t_sum[TIME_W] ? '1 : t_sum[TIME_W-1:0];
            S_UPD: begin
                r_elapsed  <= r_t;
                r_prev_spd <= r_sp;
                r_prev_gap <= r_has_next ? r_d : '0;
            end
            S_GOAL: begin
                r_goal     <= (goal_raw < SPEED_EPS) ? '0 : goal_raw;
                r_run_spd  <= r_in_spd;
                r_run_acc  <= r_in_acc;
                r_elapsed  <= '0;
                r_prev_gap <= '0;
                r_prev_spd <= '0;
            end
            S_HOLD: begin
                r_held_x    <= r_in_x;
                r_held_y    <= r_in_y;
                r_held_spd  <= r_in_spd;
                r_held_acc  <= r_in_acc;
                r_held_time <= r_in_time;
                r_has_next  <= 1'b0;
                r_d         <= '0;
                r_end       <= 1'b1;
                r_after     <= AFT_LAST;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_spd  <= r_sp;
            r_o_acc  <= r_ac;
            r_o_time <= r_t;
            r_o_end  <= r_end;
        end
    end

    assign i_pt.ready     = in_ready;
    assign o_pt.valid     = r_o_valid;
    assign o_pt.speed_out = r_o_spd;
    assign o_pt.accel_out = r_o_acc;
    assign o_pt.time_out  = r_o_time;
    assign o_pt.run_end   = r_o_end;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_goal_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && !r_bypass) |-> (r_sp >= r_goal))
        else $error("revised speed below target speed");

    a_first_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && !r_bypass && r_held_first) |-> (r_t == '0))
        else $error("start point emitted with nonzero time");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DT_WAIT || r_state == S_MAG_WAIT ||
                          r_state == S_STEP_WAIT))
        else $error("divider finished outside a wait state");

endmodule

`default_nettype wire

### test/jldp_profile_checker.sv
// ----------------------------------------------------------------------------
// jldp_profile_checker
// Watches the point channels and the register port of the deceleration
// profile block, predicts each revised point and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jldp_profile_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    jldp_pt_in_if                         pt_in,
    jldp_pt_out_if                        pt_out,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic                          i_pready,
    input  logic [jldp_pkg::APB_AW-1:0]   i_paddr,
    input  logic [jldp_pkg::APB_DW-1:0]   i_pwdata,
    output int                            o_errors,
    output int                            o_pending
);
    import jldp_pkg::*;

    typedef struct packed {
        logic [SPD_W-1:0]         speed;
        logic signed [ACC_W-1:0]  accel;
        logic [TIME_W-1:0]        tstamp;
        logic                     run_end;
    } t_point_res;

    // Register shadow
    logic [ACC_W-1:0]   cfg_min_accel;
    logic [JERK_W-1:0]  cfg_min_jerk;
    logic [RATIO_W-1:0] cfg_decel_ratio, cfg_jerk_ratio, cfg_speed_ratio;

    // Profile state
    longint h_x, h_y, h_spd, h_acc, cur_v, cur_a, goal_v, last_out_v;
    longint unsigned h_time, last_gap, t_elapsed;
    bit h_valid, h_first, pass_thru;

    t_point_res revised_q[$];
    int errors;

    assign o_errors  = errors;
    assign o_pending = revised_q.size();

    function automatic longint fl_shr16(longint p);
        return p >>> 16;
    endfunction

    function automatic longint fl_half(longint s);
        return s >>> 1;
    endfunction

    function automatic longint unsigned ratio_eff(logic [RATIO_W-1:0] r);
        return (r > RATIO_ONE) ? 65536 : r;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned seg_length(longint x0, longint y0,
                                                  longint x1, longint y1);
        longint unsigned ux, uy, sx, s;
        ux = (x1 - x0 < 0) ? x0 - x1 : x1 - x0;
        uy = (y1 - y0 < 0) ? y0 - y1 : y1 - y0;
        sx = ux * ux;
        s  = sx + uy * uy;
        if (s < sx) return 64'hFFFF_FFFF;
        return int_sqrt(s);
    endfunction

    // One S-curve step: updates running speed/accel
    task automatic revise_point(input bit has_next, input longint unsigned d,
                                output longint sp, output longint ac);
        longint v, a, vt, dt, td, j, na, nv, avg, aj, mag;
        longint unsigned q;
        bit jerk_out;
        v = cur_v; a = cur_a; vt = goal_v;
        dt = 6554;
        if (v <= vt) begin
            sp = vt; ac = 0;
            return;
        end
        if (has_next && v >= 656) begin
            q  = (d << 16) / longint'(v);
            dt = (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
        end
        td = fl_shr16(longint'($signed(cfg_min_accel)) * longint'(ratio_eff(cfg_decel_ratio)));
        j  = fl_shr16(longint'($signed(cfg_min_jerk)) * longint'(ratio_eff(cfg_jerk_ratio)));
        if (j == 0) begin
            jerk_out = a < 0;
        end else begin
            aj  = (j < 0) ? -j : j;
            mag = (a * a) / (2 * aj);
            jerk_out = (v + ((a < 0) ? -mag : mag)) <= vt;
        end
        if (jerk_out) begin
            na = a - fl_shr16(j * dt);
            if (na > 0) na = 0;
        end else if (a > td) begin
            na = a + fl_shr16(j * dt);
            if (na < td) na = td;
        end else begin
            na = td;
        end
        avg = fl_half(a + na);
        nv  = v + fl_shr16(avg * dt);
        if (nv < vt) begin nv = vt; na = 0; end
        if (nv < 0) begin nv = 0; na = 0; end
        if (nv > 8388607) nv = 8388607;
        if (na > 2097151) na = 2097151;
        if (na < -2097152) na = -2097152;
        cur_v = nv; cur_a = na;
        sp = nv; ac = na;
    endtask

    task automatic emit_held(input bit has_next, input longint unsigned d, input bit fin);
        longint sp, ac;
        longint unsigned t, avg, stp;
        t_point_res r;
        if (pass_thru) begin
            sp = h_spd; ac = h_acc; t = h_time;
        end else begin
            revise_point(has_next, d, sp, ac);
            if (h_first) begin
                t = 0;
            end else begin
                avg = (longint'(last_out_v) + sp) >> 1;
                stp = (avg >= 656) ? (last_gap * 1000000) / avg : 100000;
                t = t_elapsed + stp;
                if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
            end
            t_elapsed = t;
            last_out_v = sp;
            last_gap = has_next ? d : 0;
        end
        h_first = 0;
        r.speed = sp[SPD_W-1:0];
        r.accel = ac[ACC_W-1:0];
        r.tstamp = t[TIME_W-1:0];
        r.run_end = fin;
        revised_q.push_back(r);
    endtask

    task automatic take_point();
        longint x, y, sp, ac;
        bit st, lst;
        x = longint'($signed(pt_in.pos_x));
        y = longint'($signed(pt_in.pos_y));
        sp = pt_in.speed_in;
        ac = longint'($signed(pt_in.accel_in));
        st = pt_in.start_point;
        lst = pt_in.last_point;
        if (st) begin
            if (h_valid) emit_held(0, 0, 1);
            goal_v = (longint'(sp) * ratio_eff(cfg_speed_ratio)) >> 16;
            if (goal_v < 656) goal_v = 0;
            pass_thru = sp <= goal_v;
            cur_v = sp; cur_a = ac;
            t_elapsed = 0; last_gap = 0; last_out_v = 0;
            h_first = 1;
        end else begin
            if (!h_valid) return;
            emit_held(1, seg_length(h_x, h_y, x, y), 0);
        end
        h_x = x; h_y = y; h_spd = sp; h_acc = ac; h_time = pt_in.time_in;
        h_valid = 1;
        if (lst) begin
            emit_held(0, 0, 1);
            h_valid = 0;
        end
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Sample every transfer at the rising edge
    always @(posedge i_clk) begin
        t_point_res w;
        if (!i_rst_n) begin
            cfg_min_accel = MIN_ACCEL_RST;
            cfg_min_jerk = MIN_JERK_RST;
            cfg_decel_ratio = DECEL_RATIO_RST;
            cfg_jerk_ratio = JERK_RATIO_RST;
            cfg_speed_ratio = SPEED_RATIO_RST;
            h_valid = 0; h_first = 0; pass_thru = 0;
            h_x = 0; h_y = 0; h_spd = 0; h_acc = 0; h_time = 0;
            cur_v = 0; cur_a = 0; goal_v = 0; last_out_v = 0;
            last_gap = 0; t_elapsed = 0;
            revised_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[4:2]))
                    REG_MIN_ACCEL:   cfg_min_accel = i_pwdata[ACC_W-1:0];
                    REG_MIN_JERK:    cfg_min_jerk = i_pwdata[JERK_W-1:0];
                    REG_DECEL_RATIO: cfg_decel_ratio = i_pwdata[RATIO_W-1:0];
                    REG_JERK_RATIO:  cfg_jerk_ratio = i_pwdata[RATIO_W-1:0];
                    REG_SPEED_RATIO: cfg_speed_ratio = i_pwdata[RATIO_W-1:0];
                    default: ;
                endcase
            end
            if (pt_out.valid && pt_out.ready) begin
                if (revised_q.size() == 0) begin
                    report("unexpected point", pt_out.speed_out, 0);
                end else begin
                    w = revised_q.pop_front();
                    if (pt_out.speed_out !== w.speed)
                        report("speed_out", pt_out.speed_out, w.speed);
                    if (pt_out.accel_out !== w.accel)
                        report("accel_out", pt_out.accel_out, w.accel);
                    if (pt_out.time_out !== w.tstamp)
                        report("time_out", pt_out.time_out, w.tstamp);
                    if (pt_out.run_end !== w.run_end)
                        report("run_end", pt_out.run_end, w.run_end);
                end
            end
            if (pt_in.valid && pt_in.ready) take_point();
        end
    end

    initial errors = 0;

endmodule

### test/jerk_limited_decel_profile_top_tb.sv
// ----------------------------------------------------------------------------
// jerk_limited_decel_profile_top_tb
// Drives trajectory runs and register settings into the deceleration profile
// block with bursty input and a stalling receiver; the checker does the rest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jerk_limited_decel_profile_top_tb;
    import jldp_pkg::*;

    localparam int CYCLE_LIMIT = 5_000_000;

    logic i_clk, i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata, prdata;
    int errors, pending, cycles;
    bit rx_stall_en;

    jldp_pt_in_if  pt_in ();
    jldp_pt_out_if pt_out ();

    jerk_limited_decel_profile_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pt(pt_in.sink), .o_pt(pt_out.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    jldp_profile_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .pt_in(pt_in), .pt_out(pt_out),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Receiver stalls on its own pattern
    initial begin
        int k;
        pt_out.ready = 0;
        k = 0;
        forever begin
            @(negedge i_clk);
            k++;
            if (!rx_stall_en) pt_out.ready <= 1;
            else if ((k % 64) < 20) pt_out.ready <= (k % 3 == 0);
            else pt_out.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= APB_AW'({idx, 2'b00}); pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic set_profile(input int ma, input int mj, input int dr, input int jr,
                               input int sr);
        reg_write(REG_MIN_ACCEL, ma);
        reg_write(REG_MIN_JERK, mj);
        reg_write(REG_DECEL_RATIO, dr);
        reg_write(REG_JERK_RATIO, jr);
        reg_write(REG_SPEED_RATIO, sr);
    endtask

    // One point transfer; valid stays high into the next point when there is
    // no gap, and drops for the gap otherwise
    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [22:0] sp, input logic [21:0] ac,
                              input logic [31:0] tm, input bit st, input bit lst,
                              input int gap);
        if (gap > 0) begin
            pt_in.valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        pt_in.pos_x <= x; pt_in.pos_y <= y; pt_in.speed_in <= sp;
        pt_in.accel_in <= ac; pt_in.time_in <= tm;
        pt_in.start_point <= st; pt_in.last_point <= lst;
        pt_in.valid <= 1;
        @(posedge i_clk);
        while (!pt_in.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        pt_in.valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
    endtask

    int burst_left;

    function automatic int next_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(0, 12);
        return $urandom_range(1, 15);
    endfunction

    // One well-formed run with random content
    task automatic send_run(input int len);
        logic [31:0] x, y;
        logic [22:0] sp;
        int signed ac;
        x = $urandom; y = $urandom;
        for (int i = 0; i < len; i++) begin
            sp = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6553600)
                                             : $urandom_range(0, 1966080);
            ac = $urandom_range(0, 2621440) - 1310720;
            send_point(x, y, sp, ac[21:0], $urandom, i == 0, i == len - 1, next_gap());
            x += ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 262144);
            y += $urandom_range(0, 131072) - 65536;
        end
    endtask

    initial begin
        int sent;
        int signed ma, mj;
        i_rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        pt_in.valid = 0; pt_in.pos_x = 0; pt_in.pos_y = 0; pt_in.speed_in = 0;
        pt_in.accel_in = 0; pt_in.time_in = 0; pt_in.start_point = 0;
        pt_in.last_point = 0;
        rx_stall_en = 0; burst_left = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: defaults (speed_ratio 0), then extremes
        send_point(0, 0, 23'd6553600, 22'd0, 0, 1, 0, 0);     // point outside none
        send_point(32'h0001_0000, 0, 23'd6553600, -22'sd1310720, 5, 0, 0, 0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 0, 22'd1310720, 32'hFFFF_FFFF, 0, 0, 0);
        send_point(0, 0, 23'd100, 0, 7, 1, 0, 1);              // start inside open run
        send_point(5, 5, 23'd100, 0, 9, 0, 1, 0);
        send_point(1, 1, 23'd500, 0, 3, 0, 0, 0);              // ignored, no run open
        send_point(2, 2, 23'd655, 22'd1310720, 4, 1, 1, 0);    // one-point run
        drain();
        set_profile(-1310720, -1, 65536, 65536, 65536);        // bypass, tiny jerk
        send_point(0, 0, 23'd6553600, 0, 11, 1, 0, 0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 23'd1000, -22'sd5, 12, 0, 1, 0);
        drain();
        set_profile(0, -3276800, 0, 0, 131071);                // zero jerk limit
        send_point(0, 0, 23'd6553600, -22'sd1310720, 1, 1, 0, 0);
        send_point(0, 65536, 23'd65536, 22'd65536, 2, 0, 0, 0);
        send_point(0, 0, 23'd3000, 0, 3, 0, 1, 0);
        drain();
        set_profile(-1310720, -3276800, 131071, 131071, 32768);
        send_point(0, 0, 23'd6553600, 22'd1310720, 1, 1, 0, 0);
        send_point(32'h0100_0000, 0, 23'd6553600, 22'd1310720, 2, 0, 0, 0);
        send_point(32'h0200_0000, 0, 23'd0, -22'sd1310720, 3, 0, 1, 0);
        drain();

        // Random runs across settings
        rx_stall_en = 1;
        sent = 0;
        while (sent < 1650) begin
            ma = -$urandom_range(0, 1310720);
            mj = -$urandom_range(1, 3276800);
            set_profile(ma, mj, $urandom_range(0, 65536), $urandom_range(0, 65536),
                        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                                    : $urandom_range(0, 60000));
            for (int r = 0; r < 10; r++) begin
                int len;
                len = $urandom_range(1, 24);
                if ($urandom_range(0, 9) == 0) begin
                    // noise: stray point or a run cut by a new start
                    send_point($urandom, $urandom, $urandom_range(0, 6553600),
                               $urandom_range(0, 2621440) - 1310720, $urandom,
                               $urandom_range(0, 1), 0, next_gap());
                    sent++;
                end
                send_run(len);
                sent += len;
            end
            drain();
        end
        set_profile(-497418, -829030, 39322, 39322, 0);
        send_run(5);
        drain();

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### filelist.f
sv/jldp_pkg.sv
sv/jldp_if.sv
sv/jldp_div.sv
sv/jldp_isqrt.sv
sv/jerk_limited_decel_profile_top.sv
test/jldp_profile_checker.sv
test/jerk_limited_decel_profile_top_tb.sv
